// ----- src/chd_pkg.sv -----
package chd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      res = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      res = {1'b1, 4'(c - 8'h37)};
    end
    return res;
  endfunction

endpackage

// ----- src/chd_in_if.sv -----
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source(output valid, in_byte, end_of_message, input ready);
  modport sink(input valid, in_byte, end_of_message, output ready);
endinterface

// ----- src/chd_out_if.sv -----
interface chd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_status;
  logic [1:0] status_code;
  logic       last;

  modport source(output valid, payload_byte, is_status, status_code, last, input ready);
  modport sink(input valid, payload_byte, is_status, status_code, last, output ready);
endinterface

// ----- src/chd_result_queue.sv -----
module chd_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  chd_pkg::push_t  push,
  output logic            room,
  chd_out_if.source       out_chan
);

  localparam int DEPTH = chd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  chd_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop  = out_chan.valid && out_chan.ready;
  assign room = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

  assign out_chan.valid        = (count != '0);
  assign out_chan.payload_byte = mem[rptr].payload_byte;
  assign out_chan.is_status    = mem[rptr].is_status;
  assign out_chan.status_code  = mem[rptr].status_code;
  assign out_chan.last         = mem[rptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue count exceeds its depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("results pushed without room in the queue");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && !out_chan.ready) |=>
      (out_chan.valid && $stable({out_chan.payload_byte, out_chan.is_status,
                                  out_chan.status_code, out_chan.last})))
    else $error("offered result changed while the receiver stalled");

endmodule

// ----- src/http_chunked_decoder_unit.sv -----
// Chunked body decoder. Raw body bytes arrive on in_chan, one transfer per
// byte, with end_of_message marking the last byte of the body. Decoded payload
// bytes leave on out_chan; after the marked byte one status result follows
// with is_status and last set and the status code: complete, truncated,
// malformed size line or size overflow.
// Each accepted byte is decoded in the cycle of its transfer, and its results
// are registered in a four-entry result queue and offered on out_chan from it.
// The block takes one byte per cycle as long as the queue holds at most two
// results; a data byte that ends a message gives two results.
// When the receiver stalls, results collect in the queue and in_chan.ready
// falls once more than two are waiting; nothing is dropped.
// Reset empties the queue and puts the decoder at the start of a size line.
// After the status result the decoder returns to that same state by itself.
module http_chunked_decoder_unit #(
  parameter int SIZE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  chd_in_if.sink     in_chan,
  chd_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_SKIP1 = 3'd2,
    PH_SKIP2 = 3'd3,
    PH_DONE  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 digit_seen, digit_seen_next;
  logic                 size_ended, size_ended_next;
  logic                 saw_cr, saw_cr_next;
  logic [1:0]           error_kind, error_kind_next;

  logic            accept;
  logic            room;
  logic [7:0]      c;
  logic [4:0]      hex;
  chd_pkg::push_t  push;
  chd_pkg::result_t data_res;
  chd_pkg::result_t stat_res;
  logic            emit_data;
  logic [1:0]      code;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;
  assign c             = in_chan.in_byte;
  assign hex           = chd_pkg::hex_digit(c);

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    digit_seen_next = digit_seen;
    size_ended_next = size_ended;
    saw_cr_next     = saw_cr;
    error_kind_next = error_kind;
    emit_data       = 1'b0;
    code            = chd_pkg::ST_TRUNCATED;

    case (phase)
      PH_SIZE: begin
        if (saw_cr && c == chd_pkg::CHAR_LF) begin
          saw_cr_next = 1'b0;
          if (!digit_seen) begin
            phase_next      = PH_ERROR;
            error_kind_next = chd_pkg::ST_MALFORMED;
          end else if (bytes_left == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          saw_cr_next = (c == chd_pkg::CHAR_CR);
          if (!size_ended) begin
            if (hex[4]) begin
              if (bytes_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                phase_next      = PH_ERROR;
                error_kind_next = chd_pkg::ST_OVERFLOW;
              end else begin
                bytes_left_next = {bytes_left[SIZE_BITS-5:0], hex[3:0]};
                digit_seen_next = 1'b1;
              end
            end else if (!digit_seen &&
                         (c == chd_pkg::CHAR_SPACE || c == chd_pkg::CHAR_TAB)) begin
              size_ended_next = 1'b0;
            end else begin
              size_ended_next = 1'b1;
            end
          end
        end
      end
      PH_DATA: begin
        emit_data       = 1'b1;
        bytes_left_next = bytes_left - SIZE_BITS'(1);
        if (bytes_left == SIZE_BITS'(1)) begin
          phase_next = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        phase_next = PH_SKIP2;
      end
      PH_SKIP2: begin
        phase_next      = PH_SIZE;
        bytes_left_next = '0;
        digit_seen_next = 1'b0;
        size_ended_next = 1'b0;
        saw_cr_next     = 1'b0;
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (phase_next == PH_ERROR) begin
      code = error_kind_next;
    end else if (phase_next == PH_DONE) begin
      code = chd_pkg::ST_COMPLETE;
    end

    if (in_chan.end_of_message) begin
      phase_next      = PH_SIZE;
      bytes_left_next = '0;
      digit_seen_next = 1'b0;
      size_ended_next = 1'b0;
      saw_cr_next     = 1'b0;
      error_kind_next = chd_pkg::ST_COMPLETE;
    end
  end

  assign data_res = '{payload_byte: c, is_status: 1'b0, status_code: chd_pkg::ST_COMPLETE,
                      last: 1'b0};
  assign stat_res = '{payload_byte: 8'd0, is_status: 1'b1, status_code: code, last: 1'b1};

  always_comb begin
    push.n  = 2'd0;
    push.r0 = data_res;
    push.r1 = stat_res;
    if (accept) begin
      if (emit_data) begin
        push.n = in_chan.end_of_message ? 2'd2 : 2'd1;
      end else if (in_chan.end_of_message) begin
        push.n  = 2'd1;
        push.r0 = stat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      bytes_left <= '0;
      digit_seen <= 1'b0;
      size_ended <= 1'b0;
      saw_cr     <= 1'b0;
      error_kind <= chd_pkg::ST_COMPLETE;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      digit_seen <= digit_seen_next;
      size_ended <= size_ended_next;
      saw_cr     <= saw_cr_next;
      error_kind <= error_kind_next;
    end
  end

  chd_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_chan.end_of_message) |=>
      (phase == PH_SIZE && bytes_left == '0 && error_kind == chd_pkg::ST_COMPLETE &&
       !digit_seen))
    else $error("decoder did not restart after the end of a message");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase entered with no bytes left");

  a_two_needs_status: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (emit_data && in_chan.end_of_message))
    else $error("two results pushed for a byte that does not end a message");

endmodule
